// ===== rtl/polyev_pkg.sv =====
// Shared types, constants and fixed-point helpers of the polynomial evaluator.
// Q16.16 rounding and saturation functions used by every pipeline module.
// No dependencies.
package polyev_pkg;

  localparam int MAX_DEGREE = 5;
  localparam int FRAC_BITS  = 16;
  localparam int DW         = 32;
  localparam int SIGMA_W    = 31;
  localparam int DEG_W      = 3;
  localparam int IDX_W      = 8;
  localparam int ACC_W      = DW + 6;
  localparam int PROD_W     = 2 * DW + 2;
  localparam int NSER       = MAX_DEGREE + 1;

  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_DEGREE     = reg_idx_t'(0);
  localparam reg_idx_t REG_OFFSET     = reg_idx_t'(1);
  localparam reg_idx_t REG_CONST      = reg_idx_t'(2);
  localparam reg_idx_t REG_COEF_FIRST = reg_idx_t'(3);

  typedef logic signed [DW-1:0] fix_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [DEG_W-1:0]       degree;
    fix_t                   offset;
    fix_t                   coef0;
    fix_t [MAX_DEGREE:1]    coef;
  } cfg_t;

  typedef struct packed {
    fix_t val;
    logic ov;
  } sat_t;

  typedef struct packed {
    fix_t               x_value;
    logic [SIGMA_W-1:0] x_sigma;
    fix_t               prediction_in;
    logic [DW-1:0]      variance_in;
  } item_t;

  typedef struct packed {
    fix_t               prediction;
    fix_t               slope;
    logic [SIGMA_W-1:0] sigma;
    logic [DW-1:0]      variance;
    logic               ov;
  } mid_t;

  typedef struct packed {
    fix_t          prediction_out;
    logic [DW-1:0] variance_out;
    logic          overflow;
  } res_t;

  localparam logic signed [PROD_W-1:0] SAT_HI =
    {{(PROD_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SAT_LO =
    {{(PROD_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] RND_HALF =
    {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  function automatic sat_t sat32(input logic signed [PROD_W-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.val = SAT_HI[DW-1:0];
      r.ov  = 1'b1;
    end else if (v < SAT_LO) begin
      r.val = SAT_LO[DW-1:0];
      r.ov  = 1'b1;
    end else begin
      r.val = v[DW-1:0];
      r.ov  = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_t fmul(input fix_t a, input logic signed [DW:0] b);
    logic signed [PROD_W-1:0] ae;
    logic signed [PROD_W-1:0] be;
    logic signed [PROD_W-1:0] p;
    ae = PROD_W'(a);
    be = PROD_W'(b);
    p  = ae * be + RND_HALF;
    return sat32(p >>> FRAC_BITS);
  endfunction

  function automatic acc_t ext(input fix_t a);
    acc_t r;
    r = ACC_W'(a);
    return r;
  endfunction

endpackage

// ===== rtl/polyev_if.sv =====
// Channel interfaces of the polynomial evaluator: sample input, result output
// and configuration write. Depends on polyev_pkg.
interface polyev_in_if import polyev_pkg::*; ;
  logic               valid;
  logic               ready;
  fix_t               x_value;
  logic [SIGMA_W-1:0] x_sigma;
  fix_t               prediction_in;
  logic [DW-1:0]      variance_in;

  modport source (output valid, x_value, x_sigma, prediction_in, variance_in,
                  input ready);
  modport sink (input valid, x_value, x_sigma, prediction_in, variance_in,
                output ready);
endinterface

interface polyev_out_if import polyev_pkg::*; ;
  logic          valid;
  logic          ready;
  fix_t          prediction_out;
  logic [DW-1:0] variance_out;
  logic          overflow;

  modport source (output valid, prediction_out, variance_out, overflow,
                  input ready);
  modport sink (input valid, prediction_out, variance_out, overflow,
                output ready);
endinterface

interface polyev_cfg_if import polyev_pkg::*; ;
  logic          valid;
  logic          ready;
  reg_idx_t      index;
  logic [DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/polynomial_eval_with_error_propagation_core.sv =====
// Polynomial evaluation with first-order error propagation, Q16.16.
// Channels: in_i takes one sample point per item (covariate, sigma, prediction
// and variance so far); out_o returns one updated item per input item with
// saturated prediction, saturated variance and an overflow flag.
// cfg_i writes the degree, offset, constant and coefficient registers by
// index; it is always ready and writes above the last index are dropped.
// Write configuration only while no item is in flight.
// Pipeline: ten register stages lie between the input accept and the output.
// Throughput: one item per cycle while the receiver takes results; each of
// the ten register stages holds at most one multiply level, with the power
// chain taking one stage per degree.
// Stalls: every stage advances when it is empty or the next one advances, so
// a stalled receiver holds the output item while empty stages upstream keep
// taking input; nothing is dropped or repeated.
// Reset: asynchronous, active low; clears all pipeline valids and sets the
// degree to one with offset and coefficients at zero.
// Depends on polyev_pkg, polyev_if, polyev_cfg, polyev_series, polyev_var.
module polynomial_eval_with_error_propagation_core import polyev_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  polyev_in_if.sink       in_i,
  polyev_out_if.source    out_o,
  polyev_cfg_if.sink      cfg_i
);

  cfg_t  cfg;
  item_t item;
  mid_t  mid;
  logic  mid_valid;
  logic  mid_ready;
  res_t  res;
  logic  res_valid;

  assign cfg_i.ready = 1'b1;

  polyev_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  assign item = '{x_value:       in_i.x_value,
                  x_sigma:       in_i.x_sigma,
                  prediction_in: in_i.prediction_in,
                  variance_in:   in_i.variance_in};

  polyev_series u_series (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (item),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .item_o  (mid)
  );

  polyev_var u_var (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .item_i  (mid),
    .valid_o (res_valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.valid          = res_valid;
  assign out_o.prediction_out = res.prediction_out;
  assign out_o.variance_out   = res.variance_out;
  assign out_o.overflow       = res.overflow;

endmodule

// ===== rtl/polyev_cfg.sv =====
// Configuration register file: degree, offset and coefficients.
// Depends on polyev_pkg.
module polyev_cfg import polyev_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  input  reg_idx_t      wr_index_i,
  input  logic [DW-1:0] wr_data_i,
  output cfg_t          cfg_o
);

  logic [DEG_W-1:0]    deg_q;
  fix_t                offset_q;
  fix_t                coef0_q;
  fix_t [MAX_DEGREE:1] coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q    <= DEG_W'(1);
      offset_q <= '0;
      coef0_q  <= '0;
      coef_q   <= '0;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        REG_DEGREE: deg_q    <= wr_data_i[DEG_W-1:0];
        REG_OFFSET: offset_q <= wr_data_i;
        REG_CONST:  coef0_q  <= wr_data_i;
        default: begin
          for (int k = 1; k <= MAX_DEGREE; k++) begin
            if (wr_index_i == reg_idx_t'(int'(REG_COEF_FIRST) + k - 1)) begin
              coef_q[k] <= wr_data_i;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    cfg_o.degree = (deg_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_q;
    cfg_o.offset = offset_q;
    cfg_o.coef0  = coef0_q;
    cfg_o.coef   = coef_q;
  end

endmodule

// ===== rtl/polyev_series.sv =====
// Power series pipeline: offset subtraction, one power per stage, value and
// slope terms accumulated alongside, final saturation. Depends on polyev_pkg.
module polyev_series import polyev_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output mid_t  item_o
);

  typedef struct packed {
    fix_t               u;
    fix_t               pw;
    fix_t               val_t;
    acc_t               slope_t;
    acc_t               vacc;
    acc_t               sacc;
    logic [SIGMA_W-1:0] sigma;
    logic [DW-1:0]      variance;
    logic [DEG_W-1:0]   degree;
    logic               ov;
  } stage_t;

  stage_t          st_q [1:NSER];
  stage_t          st_d [1:NSER];
  logic [NSER:1]   v_q;
  logic [NSER+1:1] adv;
  logic            fin_v_q;
  mid_t            fin_q;
  mid_t            fin_d;

  assign adv[NSER+1] = !fin_v_q || ready_i;
  for (genvar i = 1; i <= NSER; i++) begin : g_adv
    assign adv[i] = !v_q[i] || adv[i+1];
  end
  assign ready_o = adv[1];

  // entry stage: shifted covariate, constant term folded into the value sum
  stage_t           first;
  sat_t             us;
  logic signed [DW:0] diff;

  always_comb begin
    diff          = (DW+1)'(item_i.x_value) - (DW+1)'(cfg_i.offset);
    us            = sat32(PROD_W'(diff));
    first.u       = us.val;
    first.pw      = us.val;
    first.val_t   = '0;
    first.slope_t = (cfg_i.degree >= DEG_W'(1)) ? ext(cfg_i.coef[1]) : '0;
    first.vacc    = ext(item_i.prediction_in) + ext(cfg_i.coef0);
    first.sacc    = '0;
    first.sigma   = item_i.x_sigma;
    first.variance = item_i.variance_in;
    first.degree  = cfg_i.degree;
    first.ov      = us.ov;
  end
  assign st_d[1] = first;

  for (genvar j = 1; j <= MAX_DEGREE; j++) begin : g_pow
    localparam logic [DEG_W-1:0] KV = DEG_W'(j);
    stage_t prev;
    stage_t nxt;
    sat_t   vt;
    sat_t   pn;
    acc_t   sl;
    logic   use_next;
    logic   ov_next;

    assign prev = st_q[j];

    if (j < MAX_DEGREE) begin : g_next
      localparam acc_t KMUL = ACC_W'(j + 1);
      localparam logic [DEG_W-1:0] KN = DEG_W'(j + 1);
      sat_t sn;
      assign pn       = fmul(prev.pw, (DW+1)'(prev.u));
      assign sn       = fmul(cfg_i.coef[j+1], (DW+1)'(prev.pw));
      assign sl       = ext(sn.val) * KMUL;
      assign use_next = prev.degree >= KN;
      assign ov_next  = pn.ov | sn.ov;
    end else begin : g_last
      assign pn       = '0;
      assign sl       = '0;
      assign use_next = 1'b0;
      assign ov_next  = 1'b0;
    end

    always_comb begin
      vt          = fmul(cfg_i.coef[j], (DW+1)'(prev.pw));
      nxt         = prev;
      nxt.vacc    = prev.vacc + ext(prev.val_t);
      nxt.sacc    = prev.sacc + prev.slope_t;
      nxt.val_t   = (prev.degree >= KV) ? vt.val : '0;
      nxt.pw      = pn.val;
      nxt.slope_t = use_next ? sl : '0;
      nxt.ov      = prev.ov | ((prev.degree >= KV) & vt.ov) | (use_next & ov_next);
    end
    assign st_d[j+1] = nxt;
  end

  // exit stage: close both sums and saturate
  sat_t   ps;
  sat_t   gs;
  stage_t last;

  assign last = st_q[NSER];
  always_comb begin
    ps               = sat32(PROD_W'(last.vacc + ext(last.val_t)));
    gs               = sat32(PROD_W'(last.sacc + last.slope_t));
    fin_d.prediction = ps.val;
    fin_d.slope      = gs.val;
    fin_d.sigma      = last.sigma;
    fin_d.variance   = last.variance;
    fin_d.ov         = last.ov | ps.ov | gs.ov;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      fin_v_q <= 1'b0;
    end else begin
      if (adv[1]) begin
        v_q[1] <= valid_i;
      end
      for (int i = 2; i <= NSER; i++) begin
        if (adv[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
      if (adv[NSER+1]) begin
        fin_v_q <= v_q[NSER];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 1; i <= NSER; i++) begin
      if (adv[i]) begin
        st_q[i] <= st_d[i];
      end
    end
    if (adv[NSER+1]) begin
      fin_q <= fin_d;
    end
  end

  assign valid_o = fin_v_q;
  assign item_o  = fin_q;

  a_deg_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> st_q[1].degree <= DEG_W'(MAX_DEGREE))
    else $error("degree above limit entered the pipeline");

  a_deg_zero_no_slope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] && st_q[1].degree == '0 |-> st_q[1].slope_t == '0)
    else $error("slope term present at degree zero");

  a_exit_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_v_q && ready_i |=> fin_v_q == $past(v_q[NSER]))
    else $error("exit stage did not take the next item");

endmodule

// ===== rtl/polyev_var.sv =====
// Variance pipeline: scale slope by sigma, square, add and saturate.
// Holds the output register. Depends on polyev_pkg.
module polyev_var import polyev_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  mid_t item_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  localparam int SQ_W = 2 * DW - FRAC_BITS;
  localparam logic [2*DW-1:0] SQ_HALF =
    {{(2*DW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  typedef struct packed {
    fix_t          s;
    fix_t          prediction;
    logic [DW-1:0] variance;
    logic          ov;
  } scl_t;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    fix_t            prediction;
    logic [DW-1:0]   variance;
    logic            ov;
  } sqr_t;

  logic [3:1] v_q;
  logic [4:1] adv;
  scl_t       a_q;
  scl_t       a_d;
  sqr_t       b_q;
  sqr_t       b_d;
  res_t       c_q;
  res_t       c_d;

  assign adv[4] = !v_q[3] || ready_i;
  assign adv[3] = !v_q[3] || adv[4];
  assign adv[2] = !v_q[2] || adv[3];
  assign adv[1] = !v_q[1] || adv[2];
  assign ready_o = adv[1];

  sat_t sm;
  always_comb begin
    sm             = fmul(item_i.slope, $signed({1'b0, 1'b0, item_i.sigma}));
    a_d.s          = sm.val;
    a_d.prediction = item_i.prediction;
    a_d.variance   = item_i.variance;
    a_d.ov         = item_i.ov | sm.ov;
  end

  logic signed [2*DW-1:0] se;
  logic signed [2*DW-1:0] sqp;
  logic [2*DW-1:0]        sqr;
  always_comb begin
    se             = (2*DW)'(a_q.s);
    sqp            = se * se;
    sqr            = sqp + SQ_HALF;
    b_d.sq         = sqr[2*DW-1:FRAC_BITS];
    b_d.prediction = a_q.prediction;
    b_d.variance   = a_q.variance;
    b_d.ov         = a_q.ov;
  end

  logic [SQ_W:0] vsum;
  logic          vov;
  always_comb begin
    vsum             = (SQ_W+1)'(b_q.variance) + (SQ_W+1)'(b_q.sq);
    vov              = |vsum[SQ_W:DW];
    c_d.prediction_out = b_q.prediction;
    c_d.variance_out = vov ? '1 : vsum[DW-1:0];
    c_d.overflow     = b_q.ov | vov;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) begin
        v_q[1] <= valid_i;
      end
      if (adv[2]) begin
        v_q[2] <= v_q[1];
      end
      if (adv[3]) begin
        v_q[3] <= v_q[2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      a_q <= a_d;
    end
    if (adv[2]) begin
      b_q <= b_d;
    end
    if (adv[3]) begin
      c_q <= c_d;
    end
  end

  assign valid_o = v_q[3];
  assign res_o   = c_q;

endmodule
